>>> rtl/core/bole_pkg.sv
// Shared types and constants for the bounded ordered list engine.
// No dependencies; imported by bounded_ordered_list_engine.
package bole_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 7;
	localparam int VAL_W    = 32;

	typedef enum logic [1:0] {
		RQ_INS_POS  = 2'd0,
		RQ_INS_SORT = 2'd1,
		RQ_REM_POS  = 2'd2,
		RQ_REM_VAL  = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_RANGE   = 2'd1,
		ST_FULL    = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

	typedef struct packed {
		req_kind_t                 req_type;
		logic [POS_W-1:0]          position;
		logic signed [VAL_W-1:0]   value;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VAL_W-1:0]   removed_value;
		logic [POS_W-1:0]          count;
	} rsp_t;

endpackage

>>> rtl/core/bounded_ordered_list_engine.sv
// Bounded ordered list engine: ordered list of signed words kept in one
// synchronous RAM, with positional/sorted insert and positional/value removal.
// Depends on bole_pkg.
//
// Usage:
//   Request word on req, accepted at a clock edge with start high and busy low.
//   One response word per request on rsp, valid for exactly one cycle while
//   done is high; the receiver cannot stall it. busy falls in the done cycle,
//   so the next request may be accepted there.
//   Steps: a rejected request is answered without touching the RAM. An insert
//   at p shifts the elements from the tail down to p up by one slot, then
//   writes the new word; at p = N it writes at once. A remove at p captures
//   the element at p and shifts the rest down by one slot. A remove by value
//   scans up from index 0 for an equal element, then removes it as above; a
//   value not found, or an empty list, is answered with ST_MISSING.
//   A sorted insert into an empty list writes at once; else it reads head and
//   tail, inserts at 0 or N when the value lies outside them, and otherwise
//   scans from the nearer end (head + tail against 2 * value) for the slot,
//   then shifts up and writes as above.
//   Each step moves one element through the RAM's single read and write port.
//   Reset empties the list at once; RAM contents need no clearing.
module bounded_ordered_list_engine
	import bole_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_HEAD  = 10'b00_0000_0010,
		S_TAIL  = 10'b00_0000_0100,
		S_PICK  = 10'b00_0000_1000,
		S_SCAN  = 10'b00_0001_0000,
		S_SHUP  = 10'b00_0010_0000,
		S_WRNEW = 10'b00_0100_0000,
		S_SHDN  = 10'b00_1000_0000,
		S_DRAIN = 10'b01_0000_0000,
		S_SPARE = 10'b10_0000_0000
	} state_t;

	typedef enum logic [1:0] {
		SM_EQ = 2'd0,
		SM_GE = 2'd1,
		SM_LE = 2'd2
	} scan_mode_t;

	typedef struct packed {
		logic             vld;
		logic             wr;
		logic             cap;
		logic [IDX_W-1:0] idx;
	} s1_t;

	logic [VAL_W-1:0]        mem [CAPACITY];
	logic signed [VAL_W-1:0] rdata_q;

	state_t                  state_q;
	scan_mode_t              mode_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        pos_q;
	logic [IDX_W-1:0]        ptr_q;
	logic [IDX_W-1:0]        lim_q;
	logic                    up_q;
	logic                    iss_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] head_q;
	logic signed [VAL_W-1:0] removed_q;
	logic                    done_q;
	rsp_t                    rsp_q;
	s1_t                     s1;

	logic                    issue;
	logic                    last;
	logic                    match;
	logic                    hit;
	logic                    miss;
	logic [IDX_W-1:0]        rd_addr;
	logic [IDX_W-1:0]        cnt_m1;
	logic                    we;
	logic [IDX_W-1:0]        wa;
	logic [VAL_W-1:0]        wd;
	logic signed [VAL_W+1:0] ends_sum;
	logic signed [VAL_W+1:0] twice_x;
	logic                    shup_req;
	logic [CNT_W-1:0]        shup_slot;
	logic                    fin;
	status_t                 fin_status;
	logic signed [VAL_W-1:0] fin_removed;
	logic [CNT_W-1:0]        fin_count;
	logic                    acc;

	assign acc    = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;
	assign cnt_m1 = IDX_W'(cnt_q - CNT_W'(1));

	always_comb begin
		unique case (mode_q)
			SM_EQ:   match = (rdata_q == val_q);
			SM_GE:   match = (rdata_q >= val_q);
			SM_LE:   match = (rdata_q <= val_q);
			default: match = 1'b0;
		endcase
	end

	assign hit   = (state_q == S_SCAN) && s1.vld && match;
	assign miss  = (state_q == S_SCAN) && !iss_q && !s1.vld;
	assign last  = (ptr_q == lim_q);
	assign issue = iss_q && !hit &&
		((state_q == S_SCAN) || (state_q == S_SHUP) || (state_q == S_SHDN));

	always_comb begin
		priority if (state_q == S_HEAD) begin
			rd_addr = '0;
		end else if (state_q == S_TAIL) begin
			rd_addr = cnt_m1;
		end else begin
			rd_addr = ptr_q;
		end
	end

	assign we = (s1.vld && s1.wr) || ((state_q == S_WRNEW) && !s1.vld);
	assign wa = (s1.vld && s1.wr) ? s1.idx : pos_q[IDX_W-1:0];
	assign wd = (s1.vld && s1.wr) ? rdata_q : val_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rdata_q <= mem[rd_addr];
	end

	// head + tail against 2 * value decides the scan direction
	assign ends_sum = {{2{head_q[VAL_W-1]}}, head_q} + {{2{rdata_q[VAL_W-1]}}, rdata_q};
	assign twice_x  = {val_q[VAL_W-1], val_q, 1'b0};

	always_comb begin
		shup_req  = 1'b0;
		shup_slot = '0;
		fin         = 1'b0;
		fin_status  = ST_OK;
		fin_removed = '0;
		fin_count   = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					unique case (req.req_type)
						RQ_INS_POS: begin
							if (32'(req.position) > 32'(cnt_q)) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end else if (32'(cnt_q) >= CAPACITY) begin
								fin        = 1'b1;
								fin_status = ST_FULL;
							end else begin
								shup_req  = 1'b1;
								shup_slot = CNT_W'(req.position);
							end
						end
						RQ_INS_SORT: begin
							if (32'(cnt_q) >= CAPACITY) begin
								fin        = 1'b1;
								fin_status = ST_FULL;
							end
						end
						RQ_REM_POS: begin
							if (32'(req.position) >= 32'(cnt_q)) begin
								fin        = 1'b1;
								fin_status = ST_RANGE;
							end
						end
						RQ_REM_VAL: ;
						default: ;
					endcase
				end
			end
			S_PICK: begin
				if (head_q > val_q) begin
					shup_req  = 1'b1;
					shup_slot = '0;
				end else if (rdata_q < val_q) begin
					shup_req  = 1'b1;
					shup_slot = cnt_q;
				end
			end
			S_SCAN: begin
				if (hit) begin
					if (mode_q == SM_GE) begin
						shup_req  = 1'b1;
						shup_slot = CNT_W'(s1.idx);
					end else if (mode_q == SM_LE) begin
						shup_req  = 1'b1;
						shup_slot = CNT_W'(s1.idx) + CNT_W'(1);
					end
				end else if (miss) begin
					if (mode_q == SM_EQ) begin
						fin        = 1'b1;
						fin_status = ST_MISSING;
					end else begin
						shup_req  = 1'b1;
						shup_slot = (mode_q == SM_GE) ? cnt_q : '0;
					end
				end
			end
			S_WRNEW: begin
				if (!s1.vld) begin
					fin       = 1'b1;
					fin_count = cnt_q + CNT_W'(1);
				end
			end
			S_DRAIN: begin
				if (!s1.vld) begin
					fin         = 1'b1;
					fin_removed = removed_q;
					fin_count   = cnt_q - CNT_W'(1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q  <= SM_EQ;
			cnt_q   <= '0;
			iss_q   <= 1'b0;
			up_q    <= 1'b0;
			done_q  <= 1'b0;
			s1      <= '0;
		end else begin
			done_q <= fin;

			s1.vld <= issue;
			s1.wr  <= issue && (state_q != S_SCAN) &&
				!((state_q == S_SHDN) && (CNT_W'(ptr_q) == pos_q));
			s1.cap <= issue && (state_q == S_SHDN) && (CNT_W'(ptr_q) == pos_q);
			unique case (state_q)
				S_SHUP:  s1.idx <= ptr_q + IDX_W'(1);
				S_SHDN:  s1.idx <= ptr_q - IDX_W'(1);
				default: s1.idx <= ptr_q;
			endcase

			if (issue) begin
				ptr_q <= up_q ? ptr_q + IDX_W'(1) : ptr_q - IDX_W'(1);
				if (last) begin
					iss_q <= 1'b0;
				end
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc && !fin) begin
						val_q <= req.value;
						unique case (req.req_type)
							RQ_INS_SORT: begin
								if (cnt_q == '0) begin
									pos_q   <= '0;
									state_q <= S_WRNEW;
								end else begin
									state_q <= S_HEAD;
								end
							end
							RQ_REM_POS: begin
								pos_q   <= CNT_W'(req.position);
								ptr_q   <= IDX_W'(req.position);
								lim_q   <= cnt_m1;
								up_q    <= 1'b1;
								iss_q   <= 1'b1;
								state_q <= S_SHDN;
							end
							RQ_REM_VAL: begin
								mode_q  <= SM_EQ;
								ptr_q   <= '0;
								lim_q   <= cnt_m1;
								up_q    <= 1'b1;
								iss_q   <= (cnt_q != '0);
								state_q <= S_SCAN;
							end
							default: ;
						endcase
					end
				end
				S_HEAD: state_q <= S_TAIL;
				S_TAIL: begin
					head_q  <= rdata_q;
					state_q <= S_PICK;
				end
				S_PICK: begin
					if (!shup_req) begin
						iss_q   <= 1'b1;
						state_q <= S_SCAN;
						if (twice_x < ends_sum) begin
							mode_q <= SM_GE;
							ptr_q  <= '0;
							lim_q  <= cnt_m1;
							up_q   <= 1'b1;
						end else begin
							mode_q <= SM_LE;
							ptr_q  <= cnt_m1;
							lim_q  <= '0;
							up_q   <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					if (hit && (mode_q == SM_EQ)) begin
						pos_q   <= CNT_W'(s1.idx);
						ptr_q   <= s1.idx;
						lim_q   <= cnt_m1;
						up_q    <= 1'b1;
						iss_q   <= 1'b1;
						state_q <= S_SHDN;
					end else if (fin) begin
						state_q <= S_IDLE;
					end
				end
				S_SHUP: begin
					if (issue && last) begin
						state_q <= S_WRNEW;
					end
				end
				S_SHDN: begin
					if (issue && last) begin
						state_q <= S_DRAIN;
					end
				end
				S_WRNEW, S_DRAIN: begin
					if (fin) begin
						cnt_q   <= fin_count;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase

			if (shup_req) begin
				pos_q <= shup_slot;
				if (shup_slot == cnt_q) begin
					state_q <= S_WRNEW;
				end else begin
					ptr_q   <= cnt_m1;
					lim_q   <= shup_slot[IDX_W-1:0];
					up_q    <= 1'b0;
					iss_q   <= 1'b1;
					state_q <= S_SHUP;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1.vld && s1.cap) begin
			removed_q <= rdata_q;
		end
		if (fin) begin
			rsp_q.status        <= fin_status;
			rsp_q.removed_value <= fin_removed;
			rsp_q.count         <= POS_W'(fin_count);
		end
	end

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= CAPACITY)
		else $error("element count above capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE))
		else $error("response issued while engine still working");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> (busy || done))
		else $error("accepted request neither started nor answered");

	a_s1_states: assert property (@(posedge clk) disable iff (!arst_n)
		s1.vld |-> (state_q == S_SCAN || state_q == S_SHUP || state_q == S_WRNEW ||
			state_q == S_SHDN || state_q == S_DRAIN))
		else $error("RAM pipeline word outside a scan or shift");
`endif

endmodule
